// File: rtl/unit_circle_point_defines.svh
// Assertion macros used by the unit circle point checker
`ifndef UNIT_CIRCLE_POINT_DEFINES_SVH
`define UNIT_CIRCLE_POINT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define UCP_ASSERT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define UCP_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/ucp_pkg.sv
// Package: constants, arctangent table and sideband type for unit_circle_point
package ucp_pkg;

    localparam int FRAC_BITS          = 16;
    localparam int DEF_CORDIC_STAGES  = 18;
    localparam int ATAN_LEN           = 30;

    localparam logic [29:0] DEG_PER_RAD_Q24 = 30'd961263669;
    localparam logic [26:0] RAD_PER_DEG_Q32 = 27'd74961321;
    localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;

    // wrap helpers: offset that makes the integer degrees non-negative, 1/360 in Q.32
    localparam logic [22:0] WRAP_OFFSET  = 23'd2097360;
    localparam logic [23:0] RECIP_360    = 24'd11930465;

    localparam logic [24:0] Q90  = 25'd90  << FRAC_BITS;
    localparam logic [24:0] Q180 = 25'd180 << FRAC_BITS;
    localparam logic [24:0] Q270 = 25'd270 << FRAC_BITS;
    localparam logic [24:0] Q360 = 25'd360 << FRAC_BITS;

    localparam logic [2:0] QUAD_AXIS = 3'd0;
    localparam logic [2:0] QUAD_1    = 3'd1;
    localparam logic [2:0] QUAD_2    = 3'd2;
    localparam logic [2:0] QUAD_3    = 3'd3;
    localparam logic [2:0] QUAD_4    = 3'd4;

    localparam logic [0:0] ADDR_SNAP_THRESHOLD = 1'b0;

    // atan(2^-i) in Q2.30, truncated; zero beyond the table
    function automatic logic signed [32:0] atan_q30(input int i);
        logic signed [32:0] v;
        begin
            case (i)
                0:  v = 33'sd843314856;
                1:  v = 33'sd497837829;
                2:  v = 33'sd263043836;
                3:  v = 33'sd133525158;
                4:  v = 33'sd67021686;
                5:  v = 33'sd33543515;
                6:  v = 33'sd16775850;
                7:  v = 33'sd8388437;
                8:  v = 33'sd4194282;
                9:  v = 33'sd2097149;
                10: v = 33'sd1048575;
                11: v = 33'sd524287;
                12: v = 33'sd262143;
                13: v = 33'sd131071;
                14: v = 33'sd65535;
                15: v = 33'sd32767;
                16: v = 33'sd16383;
                17: v = 33'sd8191;
                18: v = 33'sd4095;
                19: v = 33'sd2047;
                20: v = 33'sd1023;
                21: v = 33'sd511;
                22: v = 33'sd255;
                23: v = 33'sd127;
                24: v = 33'sd63;
                25: v = 33'sd31;
                26: v = 33'sd15;
                27: v = 33'sd7;
                28: v = 33'sd3;
                29: v = 33'sd1;
                default: v = 33'sd0;
            endcase
            return v;
        end
    endfunction

    // per-angle values that ride alongside the CORDIC stages
    typedef struct packed {
        logic [24:0] wdeg;
        logic [18:0] wrad;
        logic [2:0]  quad;
        logic [22:0] refa;
        logic        neg_cos;
        logic        neg_sin;
    } side_t;

endpackage

// File: rtl/unit_circle_point.sv
// A request passes the capture, conversion, wrap, quadrant, CORDIC seed, CORDIC and output register stages.
// Throughput: one request per cycle while the output is not stalled; each CORDIC iteration is its own register stage.
// A stall on the output holds the whole pipeline in place.
// Reset (rst_n, async, active low) clears all valid bits; threshold returns to 2.
// Threshold writes take effect on results leaving the last stage.
module unit_circle_point
    import ucp_pkg::*;
#(
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [0:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] angle_in,
    input  logic               unit_is_radians,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [24:0]        wrapped_degrees,
    output logic [18:0]        wrapped_radians,
    output logic signed [17:0] cosine_value,
    output logic signed [17:0] sine_value,
    output logic [2:0]         quadrant_number,
    output logic [22:0]        reference_angle
);

    localparam int N = CORDIC_STAGES;

    logic [7:0] thr_reg;
    logic       adv;

    // config register
    assign pready = 1'b1;
    assign prdata = {24'd0, thr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= 8'd2;
        else if (psel && penable && pwrite && paddr == ADDR_SNAP_THRESHOLD)
            thr_reg <= pwdata[7:0];
    end

    // whole pipeline moves unless the result is held
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // stage 1: capture
    logic               v1_reg;
    logic signed [31:0] a1_reg;
    logic               u1_reg;

    // stage 2: radians to degrees product
    logic               v2_reg;
    logic signed [31:0] a2_reg;
    logic               u2_reg;
    logic               neg2_reg;
    logic [60:0]        p2_reg;
    logic [31:0]        mag1;

    assign mag1 = a1_reg[31] ? (32'd0 - a1_reg) : a1_reg;

    // stage 3: offset integer degrees
    logic               v3_reg;
    logic [22:0]        hp3_reg;
    logic [15:0]        lo3_reg;
    logic [36:0]        p_rnd;
    logic signed [38:0] deg2;
    logic [22:0]        hp_next;

    always_comb
    begin
        p_rnd = 37'((p2_reg + 61'd8388608) >> 24);
        if (u2_reg)
            deg2 = neg2_reg ? -$signed({2'b00, p_rnd}) : $signed({2'b00, p_rnd});
        else
            deg2 = 39'(a2_reg);
        hp_next = 23'(deg2 >>> FRAC_BITS) + WRAP_OFFSET;
    end

    // stage 4: quotient by 360
    logic               v4_reg;
    logic [22:0]        hp4_reg;
    logic [15:0]        lo4_reg;
    logic [14:0]        q4_reg;
    logic [46:0]        qprod;

    assign qprod = hp3_reg * RECIP_360;

    // stage 5: wrapped degrees
    logic               v5_reg;
    logic [24:0]        w5_reg;
    logic [22:0]        rem4;

    assign rem4 = hp4_reg - 23'(q4_reg * 23'd360);

    // stage 6: quadrant, reference angle, radian products
    logic               v6_reg;
    side_t              sd6_reg;
    logic [51:0]        rp6_reg;
    logic [49:0]        zp6_reg;
    logic [2:0]         quad5;
    logic [22:0]        refa5;

    always_comb
    begin
        if (w5_reg == 25'd0 || w5_reg == Q90 || w5_reg == Q180 || w5_reg == Q270)
            quad5 = QUAD_AXIS;
        else if (w5_reg < Q90)
            quad5 = QUAD_1;
        else if (w5_reg < Q180)
            quad5 = QUAD_2;
        else if (w5_reg < Q270)
            quad5 = QUAD_3;
        else
            quad5 = QUAD_4;

        if (w5_reg <= Q90)
            refa5 = 23'(w5_reg);
        else if (w5_reg <= Q180)
            refa5 = 23'(Q180 - w5_reg);
        else if (w5_reg <= Q270)
            refa5 = 23'(w5_reg - Q180);
        else
            refa5 = 23'(Q360 - w5_reg);
    end

    // stage 7 onward: CORDIC stages, index 0 is the seed
    logic               cv_reg [0:N];
    logic signed [32:0] x_reg  [0:N];
    logic signed [32:0] y_reg  [0:N];
    logic signed [32:0] z_reg  [0:N];
    side_t              sd_reg [0:N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            cv_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            cv_reg[0] <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg   <= angle_in;
            u1_reg   <= unit_is_radians;
            a2_reg   <= a1_reg;
            u2_reg   <= u1_reg;
            neg2_reg <= a1_reg[31];
            p2_reg   <= mag1 * DEG_PER_RAD_Q24;
            hp3_reg  <= hp_next;
            lo3_reg  <= deg2[15:0];
            hp4_reg  <= hp3_reg;
            lo4_reg  <= lo3_reg;
            q4_reg   <= qprod[46:32];
            w5_reg   <= {rem4[8:0], lo4_reg};
            rp6_reg  <= w5_reg * RAD_PER_DEG_Q32;
            zp6_reg  <= refa5 * RAD_PER_DEG_Q32;
            sd6_reg.wdeg    <= w5_reg;
            sd6_reg.wrad    <= 19'd0;
            sd6_reg.quad    <= quad5;
            sd6_reg.refa    <= refa5;
            sd6_reg.neg_cos <= (w5_reg > Q90) && (w5_reg <= Q270);
            sd6_reg.neg_sin <= w5_reg > Q180;
            // seed: radians rounded, angle in Q2.30
            x_reg[0]  <= CORDIC_GAIN_Q30;
            y_reg[0]  <= 33'sd0;
            z_reg[0]  <= $signed(33'((zp6_reg + 50'(1 << (FRAC_BITS + 1))) >> (FRAC_BITS + 2)));
            sd_reg[0] <= '{wdeg: sd6_reg.wdeg,
                           wrad: 19'((rp6_reg + 52'h80000000) >> 32),
                           quad: sd6_reg.quad,
                           refa: sd6_reg.refa,
                           neg_cos: sd6_reg.neg_cos,
                           neg_sin: sd6_reg.neg_sin};
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < N; i++)
    begin : g_rot
        localparam int SH = (i < 29) ? i : 29;
        localparam logic signed [32:0] ATAN = atan_q30(i);
        logic signed [32:0] dx;
        logic signed [32:0] dy;

        assign dx = y_reg[i] >>> SH;
        assign dy = x_reg[i] >>> SH;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[i+1] <= 1'b0;
            else if (adv)
                cv_reg[i+1] <= cv_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sd_reg[i+1] <= sd_reg[i];
                if (!z_reg[i][32])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - ATAN;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + ATAN;
                end
            end
        end
    end

    // output stage: round to Q1.16, clamp, quadrant sign, snap
    localparam int RS = 30 - FRAC_BITS;
    localparam logic signed [18:0] ONE = 19'sd1 <<< FRAC_BITS;

    logic signed [18:0] c_rnd, s_rnd, c_cl, s_cl, c_sg, s_sg;
    logic [18:0]        c_mag, s_mag;
    logic signed [17:0] cos_next, sin_next;
    logic               ov_reg;
    side_t              so_reg;
    logic signed [17:0] cos_reg, sin_reg;

    always_comb
    begin
        c_rnd = 19'((x_reg[N] + 33'sd8192) >>> RS);
        s_rnd = 19'((y_reg[N] + 33'sd8192) >>> RS);
        c_cl  = (c_rnd > ONE) ? ONE : ((c_rnd < -ONE) ? -ONE : c_rnd);
        s_cl  = (s_rnd > ONE) ? ONE : ((s_rnd < -ONE) ? -ONE : s_rnd);
        c_sg  = sd_reg[N].neg_cos ? -c_cl : c_cl;
        s_sg  = sd_reg[N].neg_sin ? -s_cl : s_cl;
        c_mag = c_sg[18] ? 19'(-c_sg) : 19'(c_sg);
        s_mag = s_sg[18] ? 19'(-s_sg) : 19'(s_sg);
        cos_next = (c_mag < {11'd0, thr_reg}) ? 18'sd0 : 18'(c_sg);
        sin_next = (s_mag < {11'd0, thr_reg}) ? 18'sd0 : 18'(s_sg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= cv_reg[N];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            so_reg  <= sd_reg[N];
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign out_valid       = ov_reg;
    assign wrapped_degrees = so_reg.wdeg;
    assign wrapped_radians = so_reg.wrad;
    assign cosine_value    = cos_reg;
    assign sine_value      = sin_reg;
    assign quadrant_number = so_reg.quad;
    assign reference_angle = so_reg.refa;

endmodule

// File: rtl/ucp_checker.sv
// Port-level checker for unit_circle_point and its bind
`include "unit_circle_point_defines.svh"

module ucp_checker
    import ucp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [24:0] wrapped_degrees,
    input logic [2:0]  quadrant_number,
    input logic [22:0] reference_angle
);

    // wrapped angle stays below a full turn
    `UCP_ASSERT(a_wrap_range, out_valid, wrapped_degrees < Q360, "wrapped angle out of range")
    // reference angle is at most 90 degrees
    `UCP_ASSERT(a_ref_range, out_valid, reference_angle <= 23'(Q90), "reference angle too large")
    // first quadrant keeps the angle itself
    `UCP_ASSERT(a_quad1_ref, out_valid && quadrant_number == QUAD_1, reference_angle == 23'(wrapped_degrees), "quadrant 1 reference mismatch")
    // a held result stays offered
    `UCP_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid, "held result dropped")

endmodule

bind unit_circle_point ucp_checker u_ucp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .wrapped_degrees (wrapped_degrees),
    .quadrant_number (quadrant_number),
    .reference_angle (reference_angle)
);
